// ----- rtl/fars_pkg.sv -----
// fars_pkg: shared types and constants of the flow-affinity round-robin switch
// used by the channel interfaces and by every rtl module of the block
// no dependencies

package fars_pkg;

    // field widths of the packet key and of the routing result
    localparam int ADDR_W       = 32;
    localparam int L4_PORT_W    = 16;
    localparam int OUT_PORT_W   = 6;
    localparam int LIVE_FLOWS_W = 9;
    localparam int PORT_COUNT_W = 7;

    // default sizes handed to the top level
    localparam int FLOW_ENTRIES = 256;

    // port_count values above this are clamped
    localparam logic [PORT_COUNT_W-1:0] MAX_PORTS = PORT_COUNT_W'(64);

    // reset value of the port_count register
    localparam logic [PORT_COUNT_W-1:0] PORT_COUNT_RESET = PORT_COUNT_W'(2);

    // flow key as stored in the table
    typedef struct packed {
        logic [ADDR_W-1:0]    src_addr;
        logic [L4_PORT_W-1:0] src_port;
        logic [ADDR_W-1:0]    dst_addr;
        logic [L4_PORT_W-1:0] dst_port;
    } flow_key_t;

    // one table entry: key and the output port it was assigned
    typedef struct packed {
        flow_key_t             key;
        logic [OUT_PORT_W-1:0] port;
    } flow_entry_t;

endpackage

// ----- rtl/fars_if.sv -----
// fars_if: valid/ready channel interfaces of the switch
// packet key channel and routing result channel; depends on fars_pkg

interface fars_key_if;
    logic                          valid;
    logic                          ready;
    logic [fars_pkg::ADDR_W-1:0]    src_addr;
    logic [fars_pkg::L4_PORT_W-1:0] src_port;
    logic [fars_pkg::ADDR_W-1:0]    dst_addr;
    logic [fars_pkg::L4_PORT_W-1:0] dst_port;

    modport source (output valid, src_addr, src_port, dst_addr, dst_port, input ready);
    modport sink   (input valid, src_addr, src_port, dst_addr, dst_port, output ready);
endinterface

interface fars_res_if;
    logic                             valid;
    logic                             ready;
    logic [fars_pkg::OUT_PORT_W-1:0]   out_port;
    logic                             fresh_flow;
    logic                             table_full;
    logic [fars_pkg::LIVE_FLOWS_W-1:0] live_flows;

    modport source (output valid, out_port, fresh_flow, table_full, live_flows, input ready);
    modport sink   (input valid, out_port, fresh_flow, table_full, live_flows, output ready);
endinterface

// ----- rtl/flow_affinity_round_robin_switch.sv -----
// flow_affinity_round_robin_switch: top level of the flow-affinity switch
// holds the port_count register; instantiates fars_lookup and fars_rr
// depends on fars_pkg and fars_if
//
// usage: pkt carries one packet's flow key per transaction (valid/ready);
//   res returns one transaction per packet: out_port, fresh_flow, table_full
//   and the live_flows total after that packet. cfg_we/cfg_wdata write
//   port_count (1..64, clamped to 64, reset 2) while no packet is in flight.
// search: the table is scanned one entry per cycle through the single read
//   port of the flow memory; a new flow's result is registered once every filled
//   entry has been compared, a hit's as soon as the matching entry has been read
// packets: one at a time; the next is accepted in the same cycle as the
//   previous result first appears on res
// reset: the fill count, the round-robin pointer and the result valid clear
//   at once; table contents are not cleared, entries beyond the count are unused
// stalls: a finished result sits in the output register; the next packet is
//   still taken and searched, and only its commit waits until res.ready frees it

module flow_affinity_round_robin_switch
#(
    parameter int FLOW_ENTRIES = fars_pkg::FLOW_ENTRIES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    fars_key_if.sink                          pkt,
    fars_res_if.source                        res,
    input  logic                              cfg_we,
    input  logic [fars_pkg::PORT_COUNT_W-1:0] cfg_wdata
);

    logic [fars_pkg::PORT_COUNT_W-1:0] port_count_reg;
    logic [fars_pkg::PORT_COUNT_W-1:0] port_count_next;
    logic                              rr_advance;
    logic [fars_pkg::OUT_PORT_W-1:0]   rr_port;

    // port count register
    assign port_count_next = cfg_we ? cfg_wdata : port_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= fars_pkg::PORT_COUNT_RESET;
        end
        else
        begin
            port_count_reg <= port_count_next;
        end
    end

    // round-robin port selection
    fars_rr u_rr
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .port_count (port_count_reg),
        .advance    (rr_advance),
        .next_port  (rr_port)
    );

    // flow table and search
    fars_lookup
    #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    )
    u_lookup
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .res        (res),
        .rr_advance (rr_advance),
        .rr_port    (rr_port)
    );

endmodule

// ----- rtl/fars_rr.sv -----
// fars_rr: round-robin output port pointer
// clamps port_count to MAX_PORTS and wraps the pointer; depends on fars_pkg

module fars_rr
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [fars_pkg::PORT_COUNT_W-1:0]   port_count,
    input  logic                                advance,
    output logic [fars_pkg::OUT_PORT_W-1:0]     next_port
);

    logic [fars_pkg::OUT_PORT_W-1:0]   rr_reg;
    logic [fars_pkg::OUT_PORT_W-1:0]   rr_next;
    logic [fars_pkg::PORT_COUNT_W-1:0] limit;
    logic [fars_pkg::PORT_COUNT_W-1:0] incr;

    // effective port count and incremented pointer with wrap
    always_comb
    begin
        limit = (port_count > fars_pkg::MAX_PORTS) ? fars_pkg::MAX_PORTS : port_count;
        incr  = fars_pkg::PORT_COUNT_W'(rr_reg) + fars_pkg::PORT_COUNT_W'(1);
        if (incr >= limit)
        begin
            next_port = '0;
        end
        else
        begin
            next_port = incr[fars_pkg::OUT_PORT_W-1:0];
        end
        rr_next = advance ? next_port : rr_reg;
    end

    // pointer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_reg <= '0;
        end
        else
        begin
            rr_reg <= rr_next;
        end
    end

    // a freshly handed out port always lies below the clamped limit, or is zero
    a_port_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (rr_reg == '0) ||
                    (fars_pkg::PORT_COUNT_W'(rr_reg) < $past(limit)))
        else $error("round-robin port outside the port range");

    a_hold_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> rr_reg == $past(rr_reg))
        else $error("round-robin pointer moved without a new flow");

endmodule

// ----- rtl/fars_lookup.sv -----
// fars_lookup: flow table memory and its sequential search engine
// scans the filled entries, returns the stored port or allocates a new entry while the table has room
// depends on fars_pkg and fars_if

module fars_lookup
#(
    parameter int FLOW_ENTRIES = fars_pkg::FLOW_ENTRIES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    fars_key_if.sink                        pkt,
    fars_res_if.source                      res,
    output logic                            rr_advance,
    input  logic [fars_pkg::OUT_PORT_W-1:0] rr_port
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES = CNT_W'(FLOW_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } lookup_state_t;

    // flow table, one synchronous read port and one write port
    fars_pkg::flow_entry_t mem [FLOW_ENTRIES];
    fars_pkg::flow_entry_t rd_data_reg;

    lookup_state_t         state_reg, state_next;
    fars_pkg::flow_key_t   key_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  pend_reg, pend_next;

    logic                  ovalid_reg, ovalid_next;
    logic [fars_pkg::OUT_PORT_W-1:0]   oport_reg, oport_next;
    logic                  onew_reg, onew_next;
    logic                  ofull_reg, ofull_next;
    logic [fars_pkg::LIVE_FLOWS_W-1:0] ocount_reg, ocount_next;

    logic                  accept;
    logic                  out_free;
    logic                  hit;
    logic                  miss;
    logic                  commit;
    logic                  stall;
    logic                  rd_en;
    logic                  wr_en;
    fars_pkg::flow_entry_t wr_data;

    assign accept   = pkt.valid && pkt.ready;
    assign out_free = !ovalid_reg || res.ready;
    assign pkt.ready = (state_reg == ST_IDLE);

    // search decision: valid entries are exactly those below the fill count,
    // so only entries that were written are ever read
    always_comb
    begin
        hit    = (state_reg == ST_SCAN) && pend_reg && (rd_data_reg.key == key_reg);
        miss   = (state_reg == ST_SCAN) && !hit && (issue_reg >= count_reg);
        stall  = (hit || miss) && !out_free;
        commit = (hit || miss) && out_free;
        rd_en  = (state_reg == ST_SCAN) && !hit && (issue_reg < count_reg);
        wr_en  = miss && out_free && (count_reg < ENTRIES);
        rr_advance = miss && out_free;
        wr_data.key  = key_reg;
        wr_data.port = rr_port;
    end

    // table access; a write only happens on a miss, when no read is issued,
    // and the next scan starts after it, so accesses never overlap
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
        end
    end

    // next state of the scan and of the result register
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        pend_next   = stall ? pend_reg : rd_en;
        ovalid_next = ovalid_reg && !res.ready;
        oport_next  = oport_reg;
        onew_next   = onew_reg;
        ofull_next  = ofull_reg;
        ocount_next = ocount_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_next = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (commit)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    ovalid_next = 1'b1;
                    oport_next  = hit ? rd_data_reg.port : rr_port;
                    onew_next   = miss;
                    ofull_next  = miss && !wr_en;
                    ocount_next = fars_pkg::LIVE_FLOWS_W'(count_next);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // captured key and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.src_addr <= pkt.src_addr;
            key_reg.src_port <= pkt.src_port;
            key_reg.dst_addr <= pkt.dst_addr;
            key_reg.dst_port <= pkt.dst_port;
        end
        oport_reg  <= oport_next;
        onew_reg   <= onew_next;
        ofull_reg  <= ofull_next;
        ocount_reg <= ocount_next;
    end

    assign res.valid      = ovalid_reg;
    assign res.out_port   = oport_reg;
    assign res.fresh_flow = onew_reg;
    assign res.table_full = ofull_reg;
    assign res.live_flows = ocount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ENTRIES)
        else $error("flow count above table size");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("table read and write in the same cycle");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("fill count did not follow a table write");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("read pending while idle");

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> ovalid_reg)
        else $error("result lost on commit");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: flow table lookup, round-robin port choice and table-full checks
// of flow_affinity_round_robin_switch; needs fars_pkg, fars_if and the rtl

module testbench;

    localparam int ADDR_W       = fars_pkg::ADDR_W;
    localparam int L4_PORT_W    = fars_pkg::L4_PORT_W;
    localparam int OUT_PORT_W   = fars_pkg::OUT_PORT_W;
    localparam int LIVE_FLOWS_W = fars_pkg::LIVE_FLOWS_W;
    localparam int PORT_COUNT_W = fars_pkg::PORT_COUNT_W;
    localparam int FLOW_ENTRIES = fars_pkg::FLOW_ENTRIES;
    localparam logic [PORT_COUNT_W-1:0] MAX_PORTS        = fars_pkg::MAX_PORTS;
    localparam logic [PORT_COUNT_W-1:0] PORT_COUNT_RESET = fars_pkg::PORT_COUNT_RESET;

    typedef fars_pkg::flow_key_t flow_key_t;

    localparam int KEY_W       = $bits(flow_key_t);
    localparam int STALL_LIMIT = 8 * (FLOW_ENTRIES + 16);
    localparam int PHASE_ITEMS = 75;
    localparam int PRINT_LIMIT = 50;

    typedef enum logic [0:0] {
        ROW_PACKET,
        ROW_PORT_COUNT
    } row_kind_t;

    typedef struct packed {
        logic [OUT_PORT_W-1:0]   out_port;
        logic                    fresh_flow;
        logic                    table_full;
        logic [LIVE_FLOWS_W-1:0] live_flows;
    } route_t;

    typedef struct {
        row_kind_t               kind;
        flow_key_t               key;
        logic [PORT_COUNT_W-1:0] port_count;
        bit                      typed;
        route_t                  want;
    } directed_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [PORT_COUNT_W-1:0] cfg_wdata;

    fars_key_if pkt_if ();
    fars_res_if res_if ();

    flow_affinity_round_robin_switch u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // flow table mirror and round-robin state
    logic [OUT_PORT_W-1:0]   port_of_flow [logic [KEY_W-1:0]];
    int unsigned             stored_flows;
    logic [OUT_PORT_W-1:0]   rr_ptr;
    logic [PORT_COUNT_W-1:0] port_count_q;

    route_t        expected_routes [$];
    flow_key_t     seen_keys [$];
    directed_row_t directed_rows [$];

    bit gaps_on;
    bit stalls_on;

    int unsigned mismatch_count;
    int unsigned packets_sent;
    int unsigned fresh_flows_seen;
    int unsigned known_flows_seen;
    int unsigned full_seen;
    int unsigned port_count_writes;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic flow_key_t mk_key(input logic [ADDR_W-1:0] sa,
                                         input logic [L4_PORT_W-1:0] sp,
                                         input logic [ADDR_W-1:0] da,
                                         input logic [L4_PORT_W-1:0] dp);
        flow_key_t k;
        k.src_addr = sa;
        k.src_port = sp;
        k.dst_addr = da;
        k.dst_port = dp;
        return k;
    endfunction

    // lookup, round-robin advance and store, as the switch does per packet
    function automatic route_t route_packet(input flow_key_t k);
        route_t                  r;
        logic [KEY_W-1:0]        kb;
        logic [PORT_COUNT_W-1:0] lim;
        logic [PORT_COUNT_W-1:0] nxt;
        kb = k;
        r.table_full = 1'b0;
        if (port_of_flow.exists(kb))
        begin
            r.out_port   = port_of_flow[kb];
            r.fresh_flow = 1'b0;
        end
        else
        begin
            lim = (port_count_q > MAX_PORTS) ? MAX_PORTS : port_count_q;
            nxt = {1'b0, rr_ptr} + 7'd1;
            if (nxt >= lim)
                nxt = '0;
            rr_ptr       = nxt[OUT_PORT_W-1:0];
            r.out_port   = rr_ptr;
            r.fresh_flow = 1'b1;
            if (stored_flows < FLOW_ENTRIES)
            begin
                port_of_flow[kb] = rr_ptr;
                stored_flows++;
            end
            else
                r.table_full = 1'b1;
        end
        r.live_flows = LIVE_FLOWS_W'(stored_flows);
        return r;
    endfunction

    // random key, with each field now and then at an extreme
    function automatic flow_key_t fresh_key();
        flow_key_t k;
        k = mk_key($urandom, 16'($urandom_range(0, 65535)), $urandom,
                   16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 7) == 0) k.src_addr = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0) k.src_port = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0) k.dst_addr = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0) k.dst_port = $urandom_range(0, 1) ? '1 : '0;
        return k;
    endfunction

    // one packet transaction, with an optional idle burst in front
    task automatic send_packet(input flow_key_t k, input bit typed, input route_t want);
        route_t predicted;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            pkt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        pkt_if.valid    <= 1'b1;
        pkt_if.src_addr <= k.src_addr;
        pkt_if.src_port <= k.src_port;
        pkt_if.dst_addr <= k.dst_addr;
        pkt_if.dst_port <= k.dst_port;
        @(posedge clk);
        while (pkt_if.ready !== 1'b1)
            @(posedge clk);
        predicted = route_packet(k);
        expected_routes.push_back(typed ? want : predicted);
        seen_keys.push_back(k);
        packets_sent++;
    endtask

    // port_count write once every outstanding result is back
    task automatic write_port_count(input logic [PORT_COUNT_W-1:0] value);
        pkt_if.valid <= 1'b0;
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        port_count_q  = value;
        port_count_writes++;
    endtask

    // directed table rows
    task automatic row_packet(input flow_key_t k);
        directed_row_t row;
        row.kind       = ROW_PACKET;
        row.key        = k;
        row.port_count = '0;
        row.typed      = 1'b0;
        row.want       = '0;
        directed_rows.push_back(row);
    endtask

    task automatic row_checked(input flow_key_t k, input int port, input bit fresh,
                               input bit full, input int count);
        directed_row_t row;
        row.kind            = ROW_PACKET;
        row.key             = k;
        row.port_count      = '0;
        row.typed           = 1'b1;
        row.want.out_port   = OUT_PORT_W'(port);
        row.want.fresh_flow = fresh;
        row.want.table_full = full;
        row.want.live_flows = LIVE_FLOWS_W'(count);
        directed_rows.push_back(row);
    endtask

    task automatic row_port_count(input logic [PORT_COUNT_W-1:0] value);
        directed_row_t row;
        row.kind       = ROW_PORT_COUNT;
        row.key        = '0;
        row.port_count = value;
        row.typed      = 1'b0;
        row.want       = '0;
        directed_rows.push_back(row);
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_result();
        route_t want;
        if (expected_routes.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing outstanding, out_port %0d",
                                      res_if.out_port));
            return;
        end
        want = expected_routes.pop_front();
        if (res_if.out_port !== want.out_port)
            report_mismatch($sformatf("out_port got %0d expected %0d",
                                      res_if.out_port, want.out_port));
        if (res_if.fresh_flow !== want.fresh_flow)
            report_mismatch($sformatf("fresh_flow got %0b expected %0b",
                                      res_if.fresh_flow, want.fresh_flow));
        if (res_if.table_full !== want.table_full)
            report_mismatch($sformatf("table_full got %0b expected %0b",
                                      res_if.table_full, want.table_full));
        if (res_if.live_flows !== want.live_flows)
            report_mismatch($sformatf("live_flows got %0d expected %0d",
                                      res_if.live_flows, want.live_flows));
        if (want.table_full)
            full_seen++;
        if (want.fresh_flow)
            fresh_flows_seen++;
        else
            known_flows_seen++;
    endtask

    // result side: check transactions, stall in random bursts
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(0, 6);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pkt_if.valid === 1'b1 && pkt_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        logic [PORT_COUNT_W-1:0] phase_counts [8];
        flow_key_t               k;
        logic [KEY_W-1:0]        kb;
        route_t                  none;
        int                      pick;
        int                      flip;

        none              = '0;
        stored_flows      = 0;
        rr_ptr            = '0;
        port_count_q      = PORT_COUNT_RESET;
        mismatch_count    = 0;
        packets_sent      = 0;
        fresh_flows_seen  = 0;
        known_flows_seen  = 0;
        full_seen         = 0;
        port_count_writes = 0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        pkt_if.valid    <= 1'b0;
        pkt_if.src_addr <= '0;
        pkt_if.src_port <= '0;
        pkt_if.dst_addr <= '0;
        pkt_if.dst_port <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset port count of 2: first flow on port 1, then wrap, then hits
        row_checked(mk_key('0, '0, '0, '0), 1, 1, 0, 1);
        row_checked(mk_key('1, '1, '1, '1), 0, 1, 0, 2);
        row_checked(mk_key('0, '0, '0, '0), 1, 0, 0, 2);
        row_checked(mk_key('1, '1, '1, '1), 0, 0, 0, 2);
        row_checked(mk_key('0, '0, '0, 16'd1), 1, 1, 0, 3);
        row_packet(mk_key('0, 16'd1, '0, '0));
        row_packet(mk_key(32'd1, '0, '0, '0));
        row_packet(mk_key('0, '0, 32'd1, '0));
        // port count zero sends every new flow to port 0
        row_port_count(7'd0);
        row_checked(mk_key(32'ha5a5a5a5, 16'h5a5a, 32'h5a5a5a5a, 16'ha5a5), 0, 1, 0, 7);
        row_checked(mk_key(32'h5a5a5a5a, 16'ha5a5, 32'ha5a5a5a5, 16'h5a5a), 0, 1, 0, 8);
        row_checked(mk_key('0, '0, '0, '0), 1, 0, 0, 8);
        // port count above the maximum is clamped, pointer climbs to 5
        row_port_count(7'd127);
        row_checked(mk_key(32'h80000000, 16'h8000, 32'h80000000, 16'h8000), 1, 1, 0, 9);
        row_checked(mk_key(32'h7fffffff, 16'h7fff, 32'h7fffffff, 16'h7fff), 2, 1, 0, 10);
        row_checked(mk_key(32'h12345678, 16'h9abc, 32'hdef01234, 16'h5678), 3, 1, 0, 11);
        row_checked(mk_key('1, '0, '0, '1), 4, 1, 0, 12);
        row_checked(mk_key('0, '1, '1, '0), 5, 1, 0, 13);
        // pointer beyond a lowered port count wraps to port 0
        row_port_count(7'd3);
        row_checked(mk_key(32'hcafef00d, 16'h0bad, 32'hdeadbeef, 16'hfeed), 0, 1, 0, 14);
        row_packet(mk_key(32'h0a000001, 16'd1234, 32'hc0a80001, 16'd80));
        // a stored port outside the new port range is still returned on a hit
        row_checked(mk_key(32'h12345678, 16'h9abc, 32'hdef01234, 16'h5678), 3, 0, 0, 15);
        // single port
        row_port_count(7'd1);
        row_checked(mk_key(32'h01020304, 16'd53, 32'h08080808, 16'd53), 0, 1, 0, 16);
        row_port_count(7'd64);
        row_packet(mk_key(32'hffff0000, 16'h00ff, 32'h0000ffff, 16'hff00));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_PORT_COUNT)
                write_port_count(directed_rows[i].port_count);
            else
                send_packet(directed_rows[i].key, directed_rows[i].typed,
                            directed_rows[i].want);
        end

        // random phases, one port count each; the table fills along the way
        phase_counts = '{7'd5, 7'd127, 7'd0, 7'd1, 7'd64, 7'd65,
                         7'($urandom_range(1, 64)), 7'd2};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_port_count(phase_counts[ph]);
            if (ph == 7)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                    k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
                else if (pick == 4)
                begin
                    // known key with one bit flipped
                    kb   = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
                    flip = $urandom_range(0, KEY_W - 1);
                    kb[flip] = ~kb[flip];
                    k    = kb;
                end
                else
                    k = fresh_key();
                send_packet(k, 1'b0, none);
            end
        end

        // drain and let the switch settle
        pkt_if.valid <= 1'b0;
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (FLOW_ENTRIES + 8) @(posedge clk);

        $display("covered %0d packets over %0d port_count writes", packets_sent,
                 port_count_writes);
        $display("%0d new flows, %0d known flows, %0d refused with the table full",
                 fresh_flows_seen, known_flows_seen, full_seen);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fars_pkg.sv
rtl/fars_if.sv
rtl/fars_rr.sv
rtl/fars_lookup.sv
rtl/flow_affinity_round_robin_switch.sv
dv/testbench.sv
